@@ design/aes_pkg.sv @@
// AES-128 package: S-box tables, GF(2^8) helpers and round transforms.
// Used by the key-schedule memory control and the cipher datapath in the top level.
package aes_pkg;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXPND = 2'd1;
    localparam logic [1:0] ST_ROUND = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [7:0] GF_POLY = 8'h1b;

    typedef logic [127:0] t_block;
    typedef logic [31:0]  t_word;

    function automatic logic [7:0] sbox_fwd(input logic [7:0] x);
        logic [7:0] r;
        case (x)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Inverse S-box: invert the forward table by search-free lookup
    function automatic logic [7:0] sbox_inv(input logic [7:0] x);
        logic [7:0] r;
        case (x)
            8'h00: r=8'h52; 8'h01: r=8'h09; 8'h02: r=8'h6a; 8'h03: r=8'hd5;
            8'h04: r=8'h30; 8'h05: r=8'h36; 8'h06: r=8'ha5; 8'h07: r=8'h38;
            8'h08: r=8'hbf; 8'h09: r=8'h40; 8'h0a: r=8'ha3; 8'h0b: r=8'h9e;
            8'h0c: r=8'h81; 8'h0d: r=8'hf3; 8'h0e: r=8'hd7; 8'h0f: r=8'hfb;
            8'h10: r=8'h7c; 8'h11: r=8'he3; 8'h12: r=8'h39; 8'h13: r=8'h82;
            8'h14: r=8'h9b; 8'h15: r=8'h2f; 8'h16: r=8'hff; 8'h17: r=8'h87;
            8'h18: r=8'h34; 8'h19: r=8'h8e; 8'h1a: r=8'h43; 8'h1b: r=8'h44;
            8'h1c: r=8'hc4; 8'h1d: r=8'hde; 8'h1e: r=8'he9; 8'h1f: r=8'hcb;
            8'h20: r=8'h54; 8'h21: r=8'h7b; 8'h22: r=8'h94; 8'h23: r=8'h32;
            8'h24: r=8'ha6; 8'h25: r=8'hc2; 8'h26: r=8'h23; 8'h27: r=8'h3d;
            8'h28: r=8'hee; 8'h29: r=8'h4c; 8'h2a: r=8'h95; 8'h2b: r=8'h0b;
            8'h2c: r=8'h42; 8'h2d: r=8'hfa; 8'h2e: r=8'hc3; 8'h2f: r=8'h4e;
            8'h30: r=8'h08; 8'h31: r=8'h2e; 8'h32: r=8'ha1; 8'h33: r=8'h66;
            8'h34: r=8'h28; 8'h35: r=8'hd9; 8'h36: r=8'h24; 8'h37: r=8'hb2;
            8'h38: r=8'h76; 8'h39: r=8'h5b; 8'h3a: r=8'ha2; 8'h3b: r=8'h49;
            8'h3c: r=8'h6d; 8'h3d: r=8'h8b; 8'h3e: r=8'hd1; 8'h3f: r=8'h25;
            8'h40: r=8'h72; 8'h41: r=8'hf8; 8'h42: r=8'hf6; 8'h43: r=8'h64;
            8'h44: r=8'h86; 8'h45: r=8'h68; 8'h46: r=8'h98; 8'h47: r=8'h16;
            8'h48: r=8'hd4; 8'h49: r=8'ha4; 8'h4a: r=8'h5c; 8'h4b: r=8'hcc;
            8'h4c: r=8'h5d; 8'h4d: r=8'h65; 8'h4e: r=8'hb6; 8'h4f: r=8'h92;
            8'h50: r=8'h6c; 8'h51: r=8'h70; 8'h52: r=8'h48; 8'h53: r=8'h50;
            8'h54: r=8'hfd; 8'h55: r=8'hed; 8'h56: r=8'hb9; 8'h57: r=8'hda;
            8'h58: r=8'h5e; 8'h59: r=8'h15; 8'h5a: r=8'h46; 8'h5b: r=8'h57;
            8'h5c: r=8'ha7; 8'h5d: r=8'h8d; 8'h5e: r=8'h9d; 8'h5f: r=8'h84;
            8'h60: r=8'h90; 8'h61: r=8'hd8; 8'h62: r=8'hab; 8'h63: r=8'h00;
            8'h64: r=8'h8c; 8'h65: r=8'hbc; 8'h66: r=8'hd3; 8'h67: r=8'h0a;
            8'h68: r=8'hf7; 8'h69: r=8'he4; 8'h6a: r=8'h58; 8'h6b: r=8'h05;
            8'h6c: r=8'hb8; 8'h6d: r=8'hb3; 8'h6e: r=8'h45; 8'h6f: r=8'h06;
            8'h70: r=8'hd0; 8'h71: r=8'h2c; 8'h72: r=8'h1e; 8'h73: r=8'h8f;
            8'h74: r=8'hca; 8'h75: r=8'h3f; 8'h76: r=8'h0f; 8'h77: r=8'h02;
            8'h78: r=8'hc1; 8'h79: r=8'haf; 8'h7a: r=8'hbd; 8'h7b: r=8'h03;
            8'h7c: r=8'h01; 8'h7d: r=8'h13; 8'h7e: r=8'h8a; 8'h7f: r=8'h6b;
            8'h80: r=8'h3a; 8'h81: r=8'h91; 8'h82: r=8'h11; 8'h83: r=8'h41;
            8'h84: r=8'h4f; 8'h85: r=8'h67; 8'h86: r=8'hdc; 8'h87: r=8'hea;
            8'h88: r=8'h97; 8'h89: r=8'hf2; 8'h8a: r=8'hcf; 8'h8b: r=8'hce;
            8'h8c: r=8'hf0; 8'h8d: r=8'hb4; 8'h8e: r=8'he6; 8'h8f: r=8'h73;
            8'h90: r=8'h96; 8'h91: r=8'hac; 8'h92: r=8'h74; 8'h93: r=8'h22;
            8'h94: r=8'he7; 8'h95: r=8'had; 8'h96: r=8'h35; 8'h97: r=8'h85;
            8'h98: r=8'he2; 8'h99: r=8'hf9; 8'h9a: r=8'h37; 8'h9b: r=8'he8;
            8'h9c: r=8'h1c; 8'h9d: r=8'h75; 8'h9e: r=8'hdf; 8'h9f: r=8'h6e;
            8'ha0: r=8'h47; 8'ha1: r=8'hf1; 8'ha2: r=8'h1a; 8'ha3: r=8'h71;
            8'ha4: r=8'h1d; 8'ha5: r=8'h29; 8'ha6: r=8'hc5; 8'ha7: r=8'h89;
            8'ha8: r=8'h6f; 8'ha9: r=8'hb7; 8'haa: r=8'h62; 8'hab: r=8'h0e;
            8'hac: r=8'haa; 8'had: r=8'h18; 8'hae: r=8'hbe; 8'haf: r=8'h1b;
            8'hb0: r=8'hfc; 8'hb1: r=8'h56; 8'hb2: r=8'h3e; 8'hb3: r=8'h4b;
            8'hb4: r=8'hc6; 8'hb5: r=8'hd2; 8'hb6: r=8'h79; 8'hb7: r=8'h20;
            8'hb8: r=8'h9a; 8'hb9: r=8'hdb; 8'hba: r=8'hc0; 8'hbb: r=8'hfe;
            8'hbc: r=8'h78; 8'hbd: r=8'hcd; 8'hbe: r=8'h5a; 8'hbf: r=8'hf4;
            8'hc0: r=8'h1f; 8'hc1: r=8'hdd; 8'hc2: r=8'ha8; 8'hc3: r=8'h33;
            8'hc4: r=8'h88; 8'hc5: r=8'h07; 8'hc6: r=8'hc7; 8'hc7: r=8'h31;
            8'hc8: r=8'hb1; 8'hc9: r=8'h12; 8'hca: r=8'h10; 8'hcb: r=8'h59;
            8'hcc: r=8'h27; 8'hcd: r=8'h80; 8'hce: r=8'hec; 8'hcf: r=8'h5f;
            8'hd0: r=8'h60; 8'hd1: r=8'h51; 8'hd2: r=8'h7f; 8'hd3: r=8'ha9;
            8'hd4: r=8'h19; 8'hd5: r=8'hb5; 8'hd6: r=8'h4a; 8'hd7: r=8'h0d;
            8'hd8: r=8'h2d; 8'hd9: r=8'he5; 8'hda: r=8'h7a; 8'hdb: r=8'h9f;
            8'hdc: r=8'h93; 8'hdd: r=8'hc9; 8'hde: r=8'h9c; 8'hdf: r=8'hef;
            8'he0: r=8'ha0; 8'he1: r=8'he0; 8'he2: r=8'h3b; 8'he3: r=8'h4d;
            8'he4: r=8'hae; 8'he5: r=8'h2a; 8'he6: r=8'hf5; 8'he7: r=8'hb0;
            8'he8: r=8'hc8; 8'he9: r=8'heb; 8'hea: r=8'hbb; 8'heb: r=8'h3c;
            8'hec: r=8'h83; 8'hed: r=8'h53; 8'hee: r=8'h99; 8'hef: r=8'h61;
            8'hf0: r=8'h17; 8'hf1: r=8'h2b; 8'hf2: r=8'h04; 8'hf3: r=8'h7e;
            8'hf4: r=8'hba; 8'hf5: r=8'h77; 8'hf6: r=8'hd6; 8'hf7: r=8'h26;
            8'hf8: r=8'he1; 8'hf9: r=8'h69; 8'hfa: r=8'h14; 8'hfb: r=8'h63;
            8'hfc: r=8'h55; 8'hfd: r=8'h21; 8'hfe: r=8'h0c; 8'hff: r=8'h7d;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
    endfunction

    // Multiply by a 4-bit constant: shift-and-add over four bits
    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] k);
        logic [7:0] acc;
        logic [7:0] v;
        acc = 8'h00;
        v   = a;
        for (int i = 0; i < 4; i++) begin
            if (k[i]) begin
                acc = acc ^ v;
            end
            v = xtime(v);
        end
        return acc;
    endfunction

    // Byte i of the block sits at bits 127-8i; row i%4, column i/4
    function automatic logic [7:0] get_b(input t_block s, input int i);
        return s[127 - 8*i -: 8];
    endfunction

    function automatic t_block sub_bytes(input t_block s, input logic inv);
        t_block r;
        for (int i = 0; i < 16; i++) begin
            r[127 - 8*i -: 8] = inv ? sbox_inv(get_b(s, i)) : sbox_fwd(get_b(s, i));
        end
        return r;
    endfunction

    function automatic t_block row_shift(input t_block s, input logic inv);
        t_block r;
        r = s;
        for (int rw = 1; rw < 4; rw++) begin
            for (int c = 0; c < 4; c++) begin
                if (inv) begin
                    r[127 - 8*(((c + rw) % 4)*4 + rw) -: 8] = get_b(s, c*4 + rw);
                end else begin
                    r[127 - 8*(c*4 + rw) -: 8] = get_b(s, ((c + rw) % 4)*4 + rw);
                end
            end
        end
        return r;
    endfunction

    function automatic t_block mix_cols(input t_block s, input logic inv);
        t_block r;
        logic [3:0] cf [4];
        if (inv) begin
            cf[0] = 4'he; cf[1] = 4'hb; cf[2] = 4'hd; cf[3] = 4'h9;
        end else begin
            cf[0] = 4'h2; cf[1] = 4'h3; cf[2] = 4'h1; cf[3] = 4'h1;
        end
        for (int c = 0; c < 4; c++) begin
            for (int rw = 0; rw < 4; rw++) begin
                r[127 - 8*(c*4 + rw) -: 8] =
                    gmul(get_b(s, c*4),     cf[(4 - rw) % 4]) ^
                    gmul(get_b(s, c*4 + 1), cf[(5 - rw) % 4]) ^
                    gmul(get_b(s, c*4 + 2), cf[(6 - rw) % 4]) ^
                    gmul(get_b(s, c*4 + 3), cf[(7 - rw) % 4]);
            end
        end
        return r;
    endfunction

    function automatic t_word sub_word(input t_word w);
        return {sbox_fwd(w[31:24]), sbox_fwd(w[23:16]), sbox_fwd(w[15:8]),
                sbox_fwd(w[7:0])};
    endfunction

endpackage

@@ design/aes_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module aes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ design/aes128_block_cipher_unit.sv @@
// AES-128 encrypt/decrypt top level: key schedule, round-key memory, round datapath.
// Depends on aes_pkg and aes_ram.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------
//  input    | i_valid / o_ready    | i_action, i_data_hi, i_data_lo
//  output   | o_valid / i_ready    | o_result_hi, o_result_lo
//  config   | i_cfg_we             | i_cfg_index, i_cfg_data (key_hi, key_lo)
//
// A block runs through a key read, the initial key add and the rounds: one shared round unit
// runs one round a cycle, fed by four 32-bit round-key memories (one per column).
// The first block after reset or a key write first expands the key into those memories.
// Reset (synchronous, active low) clears the key and the schedule-valid flag.
// The block is not ready from accept until its result beat is taken.
module aes128_block_cipher_unit
    import aes_pkg::*;
#(
    parameter int CFG_IDX_W = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_action,
    input  logic [63:0]          i_data_hi,
    input  logic [63:0]          i_data_lo,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [63:0]          o_result_hi,
    output logic [63:0]          o_result_lo,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data
);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HI = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LO = CFG_IDX_W'(1);

    logic [1:0]   r_state, n_state;
    logic [63:0]  r_key_hi, r_key_lo;
    logic         r_sched_ok;
    logic         r_action;
    t_block       r_blk, n_blk;
    logic [3:0]   r_cnt, n_cnt;
    logic [3:0]   r_rnd;       // round index whose key is being read
    t_word        r_w [4];     // sliding window of the last four schedule words
    logic [7:0]   r_rcon;
    logic [3:0]   r_wr_rnd;    // round whose key the expander writes
    logic [3:0]   n_rd_rnd;
    t_word        rk_q [4];
    t_word        ex_w [4];
    t_word        ex_t;
    t_block       rk;
    t_block       rnd_out;
    logic         ex_we;
    logic         accept;

    assign accept  = i_valid && o_ready;
    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = (r_state == ST_DONE);
    assign o_result_hi = r_blk[127:64];
    assign o_result_lo = r_blk[63:0];

    // Next four schedule words from the previous four (one round key per cycle)
    always_comb begin
        ex_t = sub_word({r_w[3][23:0], r_w[3][31:24]}) ^ {r_rcon, 24'h0};
        ex_w[0] = r_w[0] ^ ex_t;
        ex_w[1] = r_w[1] ^ ex_w[0];
        ex_w[2] = r_w[2] ^ ex_w[1];
        ex_w[3] = r_w[3] ^ ex_w[2];
    end
    assign ex_we = (r_state == ST_EXPND);

    // Round-key memories, one per column word
    for (genvar g = 0; g < 4; g++) begin : g_rk
        aes_ram #(.WIDTH(32), .DEPTH(11)) u_rk (
            .i_clk   (i_clk),
            .i_we    (ex_we),
            .i_waddr (r_wr_rnd),
            .i_wdata (r_w[g]),
            .i_raddr (n_rd_rnd),
            .o_rdata (rk_q[g])
        );
    end
    assign rk = {rk_q[0], rk_q[1], rk_q[2], rk_q[3]};

    // Shared round unit; the last round (cnt 11) skips the column mix
    always_comb begin
        t_block s;
        if (!r_action) begin
            s = row_shift(sub_bytes(r_blk, 1'b0), 1'b0);
            if (r_cnt != 4'd11) begin
                s = mix_cols(s, 1'b0);
            end
            rnd_out = s ^ rk;
        end else begin
            s = sub_bytes(row_shift(r_blk, 1'b1), 1'b1) ^ rk;
            if (r_cnt != 4'd11) begin
                s = mix_cols(s, 1'b1);
            end
            rnd_out = s;
        end
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_blk    = r_blk;
        n_cnt    = r_cnt;
        n_rd_rnd = r_rnd;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (r_sched_ok) begin
                        n_state  = ST_ROUND;
                        n_cnt    = 4'd0;
                        n_rd_rnd = i_action ? 4'd10 : 4'd0;
                    end else begin
                        n_state = ST_EXPND;
                    end
                    n_blk = {i_data_hi, i_data_lo};
                end
            end
            ST_EXPND: begin
                if (r_wr_rnd == 4'd10) begin
                    n_state  = ST_ROUND;
                    n_cnt    = 4'd0;
                    n_rd_rnd = r_action ? 4'd10 : 4'd0;
                end
            end
            ST_ROUND: begin
                // cnt 0: key read in flight; 1: initial add; 2..11: rounds
                n_cnt = r_cnt + 4'd1;
                if (r_cnt != 4'd0 && r_cnt != 4'd11) begin
                    n_rd_rnd = r_action ? r_rnd - 4'd1 : r_rnd + 4'd1;
                end
                if (r_cnt == 4'd1) begin
                    n_blk = r_blk ^ rk;
                end else if (r_cnt != 4'd0) begin
                    n_blk = rnd_out;
                end
                if (r_cnt == 4'd11) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_key_hi   <= 64'h0;
            r_key_lo   <= 64'h0;
            r_sched_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && i_cfg_index == REG_KEY_HI) begin
                r_key_hi   <= i_cfg_data;
                r_sched_ok <= 1'b0;
            end else if (i_cfg_we && i_cfg_index == REG_KEY_LO) begin
                r_key_lo   <= i_cfg_data;
                r_sched_ok <= 1'b0;
            end else if (r_state == ST_EXPND && r_wr_rnd == 4'd10) begin
                r_sched_ok <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        r_cnt <= n_cnt;
        r_rnd <= n_rd_rnd;
        if (accept) begin
            r_action <= i_action;
            r_w[0]   <= r_key_hi[63:32];
            r_w[1]   <= r_key_hi[31:0];
            r_w[2]   <= r_key_lo[63:32];
            r_w[3]   <= r_key_lo[31:0];
            r_rcon   <= 8'h01;
            r_wr_rnd <= 4'd0;
        end else if (r_state == ST_EXPND) begin
            r_w      <= ex_w;
            r_rcon   <= xtime(r_rcon);
            r_wr_rnd <= r_wr_rnd + 4'd1;
        end
    end
endmodule
